FILE: sv/psip_master_guide_table_parser_core_defines.svh
// Assertion macros for the MGT parser core.
`ifndef PSIP_MASTER_GUIDE_TABLE_PARSER_CORE_DEFINES_SVH
`define PSIP_MASTER_GUIDE_TABLE_PARSER_CORE_DEFINES_SVH
`ifndef SYNTH
`define PSIP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PSIP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PSIP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define PSIP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: sv/psip_mgt_pkg.sv
package psip_mgt_pkg;

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_RECORD = 6'b000010,
        PH_SKIP   = 6'b000100,
        PH_GLEN   = 6'b001000,
        PH_GSKIP  = 6'b010000,
        PH_TAIL   = 6'b100000
    } t_phase;

    localparam logic [1:0] ST_VALID = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    localparam logic KIND_ENTRY = 1'b0;
    localparam logic KIND_END   = 1'b1;

    localparam logic [3:0] HDR_LAST_POS = 4'd2;
    localparam logic [3:0] REC_LAST_POS = 4'd10;

    localparam int QAW    = 2;
    localparam int QDEPTH = 1 << QAW;

    typedef struct packed {
        logic        entry_v;
        logic        end_v;
        logic [15:0] e_type;
        logic [12:0] e_pid;
        logic [4:0]  e_ver;
        logic [31:0] e_size;
        logic [11:0] e_dl;
        logic [11:0] x_dl;
        logic [7:0]  x_pv;
        logic [1:0]  x_st;
    } t_evt;

endpackage

FILE: sv/psip_master_guide_table_parser_core.sv
// MGT section payload parser: takes one payload byte per cycle whenever full is low and
// returns one entry request per table-type record and one end summary after the byte marked
// last. Results go through a 4-deep request queue and an output register: a result is
// written into the queue at the edge that accepts the byte causing it and is then loaded
// into the output register. A byte that both closes a record and ends the payload yields
// two results from one queue slot, the entry request first and then the end summary. Full
// is high when the request queue holds four pending requests.
module psip_master_guide_table_parser_core
    import psip_mgt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic        o_kind,
    output logic [15:0] o_table_type,
    output logic [12:0] o_table_pid,
    output logic [4:0]  o_table_version,
    output logic [31:0] o_table_size_bytes,
    output logic [11:0] o_descriptor_length,
    output logic [7:0]  o_protocol_version,
    output logic [1:0]  o_status,
    output logic        o_last
);

    logic q_full;
    logic q_wr;
    logic q_rd;
    logic q_nempty;
    t_evt q_in;
    t_evt q_head;

    psip_mgt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (q_full),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_wr        (q_wr),
        .o_evt       (q_in)
    );

    psip_mgt_evq u_evq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (q_wr),
        .i_evt    (q_in),
        .i_rd     (q_rd),
        .o_full   (q_full),
        .o_nempty (q_nempty),
        .o_head   (q_head)
    );

    psip_mgt_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_nempty            (q_nempty),
        .i_head              (q_head),
        .i_pop               (pop),
        .o_rd                (q_rd),
        .o_empty             (empty),
        .o_kind              (o_kind),
        .o_table_type        (o_table_type),
        .o_table_pid         (o_table_pid),
        .o_table_version     (o_table_version),
        .o_table_size_bytes  (o_table_size_bytes),
        .o_descriptor_length (o_descriptor_length),
        .o_protocol_version  (o_protocol_version),
        .o_status            (o_status),
        .o_last              (o_last)
    );

    assign full = q_full;

endmodule

FILE: sv/psip_mgt_front.sv
`include "psip_master_guide_table_parser_core_defines.svh"

module psip_mgt_front
    import psip_mgt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_wr,
    output t_evt       o_evt
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_pos, n_pos;
    logic [15:0] r_left, n_left;
    logic [7:0]  r_proto, n_proto;
    logic [15:0] r_type, n_type;
    logic [12:0] r_pid, n_pid;
    logic [4:0]  r_ver, n_ver;
    logic [31:0] r_size, n_size;
    logic [11:0] r_skip, n_skip;
    logic [11:0] r_seen, n_seen;

    logic acc;
    logic emit;
    t_evt ev;

    assign acc = i_push && !i_full;

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_left  = r_left;
        n_proto = r_proto;
        n_type  = r_type;
        n_pid   = r_pid;
        n_ver   = r_ver;
        n_size  = r_size;
        n_skip  = r_skip;
        n_seen  = r_seen;
        emit    = 1'b0;
        ev      = '0;
        if (acc) begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_pos == 4'd0) begin
                        n_proto = i_data_byte;
                    end else if (r_pos == 4'd1) begin
                        n_left = {i_data_byte, 8'h00};
                    end else begin
                        n_left = r_left | {8'h00, i_data_byte};
                    end
                    if (r_pos >= HDR_LAST_POS) begin
                        n_pos   = 4'd0;
                        n_phase = (n_left != 16'd0) ? PH_RECORD : PH_GLEN;
                    end else begin
                        n_pos = r_pos + 4'd1;
                    end
                end
                PH_RECORD: begin
                    case (r_pos)
                        4'd0: n_type = {i_data_byte, 8'h00};
                        4'd1: n_type = r_type | {8'h00, i_data_byte};
                        4'd2: n_pid = {i_data_byte[4:0], 8'h00};
                        4'd3: n_pid = r_pid | {5'd0, i_data_byte};
                        4'd4: n_ver = i_data_byte[4:0];
                        4'd5: n_size = {i_data_byte, 24'h000000};
                        4'd6: n_size = r_size | {8'h00, i_data_byte, 16'h0000};
                        4'd7: n_size = r_size | {16'h0000, i_data_byte, 8'h00};
                        4'd8: n_size = r_size | {24'h000000, i_data_byte};
                        4'd9: n_skip = {i_data_byte[3:0], 8'h00};
                        default: begin
                            n_skip = r_skip | {4'd0, i_data_byte};
                            n_seen = 12'd0;
                        end
                    endcase
                    if (r_pos >= REC_LAST_POS) begin
                        n_pos = 4'd0;
                        if (n_skip == 12'd0) begin
                            emit = 1'b1;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end else begin
                        n_pos = r_pos + 4'd1;
                    end
                end
                PH_SKIP: begin
                    n_seen = r_seen + 12'd1;
                    if (n_seen == r_skip) begin
                        emit = 1'b1;
                    end
                end
                PH_GLEN: begin
                    if (r_pos == 4'd0) begin
                        n_skip = {i_data_byte[3:0], 8'h00};
                        n_pos  = 4'd1;
                    end else begin
                        n_skip  = r_skip | {4'd0, i_data_byte};
                        n_seen  = 12'd0;
                        n_pos   = 4'd0;
                        n_phase = (n_skip != 12'd0) ? PH_GSKIP : PH_TAIL;
                    end
                end
                PH_GSKIP: begin
                    n_seen = r_seen + 12'd1;
                    if (n_seen == r_skip) begin
                        n_phase = PH_TAIL;
                    end
                end
                PH_TAIL: begin
                    n_phase = PH_TAIL;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase

            if (emit) begin
                n_left  = n_left - 16'd1;
                n_phase = (n_left != 16'd0) ? PH_RECORD : PH_GLEN;
                n_pos   = 4'd0;
            end

            ev.entry_v = emit;
            ev.e_type  = n_type;
            ev.e_pid   = n_pid;
            ev.e_ver   = n_ver;
            ev.e_size  = n_size;
            ev.e_dl    = n_seen;

            if (i_last_byte) begin
                // flush an entry cut short inside its descriptors
                if (n_phase == PH_SKIP) begin
                    ev.entry_v = 1'b1;
                end
                ev.end_v = 1'b1;
                if (n_phase == PH_HEADER) begin
                    ev.x_st = ST_SHORT;
                    ev.x_pv = 8'h00;
                    ev.x_dl = 12'd0;
                end else if (n_phase == PH_GSKIP || n_phase == PH_TAIL) begin
                    ev.x_st = ST_VALID;
                    ev.x_pv = n_proto;
                    ev.x_dl = n_seen;
                end else begin
                    ev.x_st = ST_TRUNC;
                    ev.x_pv = n_proto;
                    ev.x_dl = 12'd0;
                end
                n_phase = PH_HEADER;
                n_pos   = 4'd0;
                n_left  = 16'd0;
                n_proto = 8'h00;
                n_type  = 16'd0;
                n_pid   = 13'd0;
                n_ver   = 5'd0;
                n_size  = 32'd0;
                n_skip  = 12'd0;
                n_seen  = 12'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= 4'd0;
            r_left  <= 16'd0;
            r_proto <= 8'h00;
            r_type  <= 16'd0;
            r_pid   <= 13'd0;
            r_ver   <= 5'd0;
            r_size  <= 32'd0;
            r_skip  <= 12'd0;
            r_seen  <= 12'd0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_left  <= n_left;
            r_proto <= n_proto;
            r_type  <= n_type;
            r_pid   <= n_pid;
            r_ver   <= n_ver;
            r_size  <= n_size;
            r_skip  <= n_skip;
            r_seen  <= n_seen;
        end
    end

    assign o_wr  = acc && (ev.entry_v || ev.end_v);
    assign o_evt = ev;

    `PSIP_ASSERT_NOW(a_skip_nonzero, i_clk, i_rst_n, r_phase == PH_SKIP, r_skip != 12'd0,
        "descriptor skip entered with zero length")
    `PSIP_ASSERT_NOW(a_hdr_pos, i_clk, i_rst_n, r_phase == PH_HEADER, r_pos <= HDR_LAST_POS,
        "header position out of range")

endmodule

FILE: sv/psip_mgt_evq.sv
`include "psip_master_guide_table_parser_core_defines.svh"

module psip_mgt_evq
    import psip_mgt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_evt i_evt,
    input  logic i_rd,
    output logic o_full,
    output logic o_nempty,
    output t_evt o_head
);

    t_evt           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, n_wp;
    logic [QAW-1:0] r_rp, n_rp;
    logic [QAW:0]   r_cnt, n_cnt;
    logic           wr;
    logic           rd;

    assign o_full   = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_head   = r_mem[r_rp];

    assign wr = i_wr && !o_full;
    assign rd = i_rd && o_nempty;

    always_comb begin
        n_wp  = wr ? r_wp + 1'b1 : r_wp;
        n_rp  = rd ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (wr && !rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd && !wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_evt;
        end
    end

    `PSIP_ASSERT_NXT(a_q_inc, i_clk, i_rst_n, wr && !rd, r_cnt == $past(r_cnt) + 1'b1,
        "queue count did not advance on push")

endmodule

FILE: sv/psip_mgt_back.sv
`include "psip_master_guide_table_parser_core_defines.svh"

module psip_mgt_back
    import psip_mgt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_nempty,
    input  t_evt        i_head,
    input  logic        i_pop,
    output logic        o_rd,
    output logic        o_empty,
    output logic        o_kind,
    output logic [15:0] o_table_type,
    output logic [12:0] o_table_pid,
    output logic [4:0]  o_table_version,
    output logic [31:0] o_table_size_bytes,
    output logic [11:0] o_descriptor_length,
    output logic [7:0]  o_protocol_version,
    output logic [1:0]  o_status,
    output logic        o_last
);

    logic        r_ov;
    logic        r_entry_done;
    logic        r_kind;
    logic [15:0] r_type;
    logic [12:0] r_pid;
    logic [4:0]  r_ver;
    logic [31:0] r_size;
    logic [11:0] r_dl;
    logic [7:0]  r_pv;
    logic [1:0]  r_st;
    logic        r_last;

    logic sel_entry;
    logic load;

    assign sel_entry = i_head.entry_v && !r_entry_done;
    assign load      = i_nempty && (!r_ov || i_pop);
    assign o_rd      = load && !(sel_entry && i_head.end_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov         <= 1'b0;
            r_entry_done <= 1'b0;
        end else begin
            if (load) begin
                r_ov         <= 1'b1;
                r_entry_done <= sel_entry && i_head.end_v;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (sel_entry) begin
                r_kind <= KIND_ENTRY;
                r_type <= i_head.e_type;
                r_pid  <= i_head.e_pid;
                r_ver  <= i_head.e_ver;
                r_size <= i_head.e_size;
                r_dl   <= i_head.e_dl;
                r_pv   <= 8'h00;
                r_st   <= ST_VALID;
                r_last <= !i_head.end_v;
            end else begin
                r_kind <= KIND_END;
                r_type <= 16'd0;
                r_pid  <= 13'd0;
                r_ver  <= 5'd0;
                r_size <= 32'd0;
                r_dl   <= i_head.x_dl;
                r_pv   <= i_head.x_pv;
                r_st   <= i_head.x_st;
                r_last <= 1'b1;
            end
        end
    end

    assign o_empty             = !r_ov;
    assign o_kind              = r_kind;
    assign o_table_type        = r_type;
    assign o_table_pid         = r_pid;
    assign o_table_version     = r_ver;
    assign o_table_size_bytes  = r_size;
    assign o_descriptor_length = r_dl;
    assign o_protocol_version  = r_pv;
    assign o_status            = r_st;
    assign o_last              = r_last;

    `PSIP_ASSERT_NOW(a_done_head, i_clk, i_rst_n, r_entry_done,
        i_nempty && i_head.entry_v && i_head.end_v, "split request lost its head")
    `PSIP_ASSERT_NOW(a_entry_pend, i_clk, i_rst_n, r_ov && r_kind == KIND_ENTRY && !r_last,
        r_entry_done, "entry shown without its summary pending")

endmodule
